>>> hdl/dbd_pkg.sv
package dbd_pkg;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DIST_W  = 22;
	localparam int ORDER_W = 2;

	localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// order codes
	localparam logic [ORDER_W-1:0] ORDER_EQUAL         = 2'd0;
	localparam logic [ORDER_W-1:0] ORDER_FIRST_LATER   = 2'd1;
	localparam logic [ORDER_W-1:0] ORDER_FIRST_EARLIER = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

	// shared multiplier: year times 365, or year times reciprocal of 100
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	localparam logic [RECIP_W-1:0] DAYS_YEAR = RECIP_W'(365);
	localparam int PROD_W = YEAR_W + RECIP_W;
	localparam int CENT_W = PROD_W - RECIP_SHIFT;

	localparam int ACC_W = DIST_W + 2;
	localparam int DOY_W = 9;
	localparam int CNT_W = YEAR_W - 2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_ACCY = 6'b000100,
		ST_LEAP = 6'b001000,
		ST_ACCC = 6'b010000,
		ST_DONE = 6'b100000
	} dbd_state_t;

	typedef struct packed {
		logic capture;
		logic mul_en;
		logic mul_recip;
		logic leap_en;
		logic acc_en;
		logic acc_cnt;
		logic date_sel;
		logic out_load;
	} dbd_cmd_t;

	// days in the months before month m, common year; months past twelve count 30
	function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] r;
		unique case (m)
			4'd0:  r = 9'd0;
			4'd1:  r = 9'd0;
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			4'd13: r = 9'd365;
			4'd14: r = 9'd395;
			4'd15: r = 9'd425;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/dbd_ctrl.sv
module dbd_ctrl import dbd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dbd_cmd_t cmd
);

	dbd_state_t state_q, state_d;
	logic       sel_q;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.date_sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ACCY;
			end
			ST_ACCY: begin
				cmd.acc_en    = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_recip = 1'b1;
				state_d       = ST_LEAP;
			end
			ST_LEAP: begin
				cmd.leap_en = 1'b1;
				state_d     = ST_ACCC;
			end
			ST_ACCC: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_cnt = 1'b1;
				state_d     = sel_q ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture)
				sel_q <= 1'b0;
			else if (cmd.acc_cnt)
				sel_q <= 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> hdl/dbd_datapath.sv
module dbd_datapath import dbd_pkg::*; (
	input  logic                clk,
	input  dbd_cmd_t            cmd,
	input  logic [DAY_W-1:0]    first_day,
	input  logic [MONTH_W-1:0]  first_month,
	input  logic [YEAR_W-1:0]   first_year,
	input  logic [DAY_W-1:0]    second_day,
	input  logic [MONTH_W-1:0]  second_month,
	input  logic [YEAR_W-1:0]   second_year,
	output logic [DIST_W-1:0]   day_distance,
	output logic [ORDER_W-1:0]  order
);

	logic [YEAR_W-1:0]  fy, sy;
	logic [ORDER_W-1:0] ord;
	logic               swap;

	logic [DAY_W-1:0]   late_day_q, early_day_q;
	logic [MONTH_W-1:0] late_month_q, early_month_q;
	logic [YEAR_W-1:0]  late_year_q, early_year_q;
	logic [ORDER_W-1:0] order_q;

	logic [DAY_W-1:0]   cur_day;
	logic [MONTH_W-1:0] cur_month;
	logic [YEAR_W-1:0]  cur_year;

	logic [PROD_W-1:0]  prod_q;
	logic [RECIP_W-1:0] mul_b;

	logic [CENT_W-1:0]  cent, cent_t;
	logic               zero_cent;
	logic               leap;
	logic [YEAR_W-1:0]  year_m1;
	logic [CNT_W-1:0]   leap_sum, leaps;
	logic [DOY_W-1:0]   doy;
	logic [CNT_W-1:0]   cnt_q;

	logic        [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] acc_q;
	logic [DIST_W-1:0]       dist_sat;

	logic [DIST_W-1:0]  day_distance_q;
	logic [ORDER_W-1:0] order_out_q;

	// saturate years, compare, put the later date first
	always_comb begin
		fy = (first_year > MAX_YEAR) ? MAX_YEAR : first_year;
		sy = (second_year > MAX_YEAR) ? MAX_YEAR : second_year;
		if (fy != sy)
			ord = (fy > sy) ? ORDER_FIRST_LATER : ORDER_FIRST_EARLIER;
		else if (first_month != second_month)
			ord = (first_month > second_month) ? ORDER_FIRST_LATER : ORDER_FIRST_EARLIER;
		else if (first_day != second_day)
			ord = (first_day > second_day) ? ORDER_FIRST_LATER : ORDER_FIRST_EARLIER;
		else
			ord = ORDER_EQUAL;
		swap = (ord == ORDER_FIRST_EARLIER);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			late_day_q    <= swap ? second_day   : first_day;
			late_month_q  <= swap ? second_month : first_month;
			late_year_q   <= swap ? sy           : fy;
			early_day_q   <= swap ? first_day    : second_day;
			early_month_q <= swap ? first_month  : second_month;
			early_year_q  <= swap ? fy           : sy;
			order_q       <= ord;
		end
	end

	assign cur_day   = cmd.date_sel ? early_day_q   : late_day_q;
	assign cur_month = cmd.date_sel ? early_month_q : late_month_q;
	assign cur_year  = cmd.date_sel ? early_year_q  : late_year_q;

	assign mul_b = cmd.mul_recip ? RECIP_100 : DAYS_YEAR;

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= PROD_W'(cur_year) * PROD_W'(mul_b);
	end

	// leap years before cur_year and day of year, from year * reciprocal of 100
	always_comb begin
		cent      = prod_q[PROD_W-1:RECIP_SHIFT];
		zero_cent = (prod_q[RECIP_SHIFT-1:0] < RECIP_SHIFT'(RECIP_100));
		cent_t    = cent - CENT_W'(zero_cent);
		year_m1   = cur_year - YEAR_W'(1);
		leap_sum  = year_m1[YEAR_W-1:2] - CNT_W'(cent_t)
			+ CNT_W'(cent_t[CENT_W-1:2]) + CNT_W'(1);
		leaps     = (cur_year != '0) ? leap_sum : '0;
		leap      = (cur_year[1:0] == 2'b00) && (!zero_cent || (cent[1:0] == 2'b00));
		doy       = month_offset(cur_month)
			+ DOY_W'(leap && (cur_month >= MONTH_MARCH)) + DOY_W'(cur_day);
	end

	always_ff @(posedge clk) begin
		if (cmd.leap_en)
			cnt_q <= leaps + CNT_W'(doy);
	end

	// later date adds, earlier date subtracts
	assign addend = cmd.acc_cnt ? ACC_W'(cnt_q) : prod_q[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture)
			acc_q <= '0;
		else if (cmd.acc_en)
			acc_q <= cmd.date_sel ? acc_q - $signed(addend) : acc_q + $signed(addend);
	end

	always_comb begin
		if (acc_q < 0)
			dist_sat = '0;
		else if (acc_q > $signed(ACC_W'(DIST_MAX)))
			dist_sat = DIST_MAX;
		else
			dist_sat = acc_q[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			day_distance_q <= dist_sat;
			order_out_q    <= order_q;
		end
	end

	assign day_distance = day_distance_q;
	assign order        = order_out_q;

endmodule

>>> hdl/days_between_dates.sv
// Day distance between two proleptic Gregorian dates (year 0 is a leap year).
// One transaction on the input channel carries both dates; one transaction on
// the output channel returns the absolute day count and which date is later
// (0 equal, 1 first later, 2 first earlier). Years above 9999 are clamped to
// 9999 and the day field is used as given, unchecked against the month. Each
// date is turned into a day number 365*y + leap years before y + day of year,
// and the two are subtracted; a negative result reads as zero. A controller
// steps a datapath with one shared 14x13 multiplier and one accumulator in four
// steps per date: year times 365; year times the reciprocal of 100 while 365*y
// is accumulated; leap and day-of-year count; accumulate that count. After the
// second date the result is loaded into the output register once that register
// is free. The input side takes the next transaction as soon as the result is
// loaded, even while it still waits to be taken.
module days_between_dates import dbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DAY_W-1:0]    first_day,
	input  logic [MONTH_W-1:0]  first_month,
	input  logic [YEAR_W-1:0]   first_year,
	input  logic [DAY_W-1:0]    second_day,
	input  logic [MONTH_W-1:0]  second_month,
	input  logic [YEAR_W-1:0]   second_year,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DIST_W-1:0]   day_distance,
	output logic [ORDER_W-1:0]  order
);

	// command bundle from the sequencer to the arithmetic
	dbd_cmd_t cmd;

	// sequencer: idle, two passes of four steps, then wait for the output slot
	dbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// capture and order, shared multiplier, leap count, accumulator, output register
	dbd_datapath u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.first_day    (first_day),
		.first_month  (first_month),
		.first_year   (first_year),
		.second_day   (second_day),
		.second_month (second_month),
		.second_year  (second_year),
		.day_distance (day_distance),
		.order        (order)
	);

	// a taken transaction closes the input side until the result is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in progress");

	// equal dates always give a zero distance
	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (order == ORDER_EQUAL) |-> (day_distance == '0))
		else $error("equal dates with nonzero distance");

	// only defined order codes leave the block
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (order == ORDER_EQUAL) || (order == ORDER_FIRST_LATER)
			|| (order == ORDER_FIRST_EARLIER))
		else $error("undefined order code");

	// a result is loaded only from the final step, never with the input side open
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ready && !cmd.capture)
		else $error("result loaded outside the final step");

endmodule
